### hw/rtl/bllf_pkg.sv
// Shared types, constants and command/status words for the bid ladder line fit.
// Used by every module under hw/rtl; depends on nothing.
package bllf_pkg;

    // Field widths
    localparam int QTY_W   = 20;
    localparam int PRICE_W = 20;
    localparam int CFG_W   = 20;
    localparam int A_W     = 47;
    localparam int B_W     = 48;

    // Ladder state widths
    localparam int CUM_W   = 25;
    localparam int SX_W    = 29;
    localparam int SY_W    = 29;
    localparam int SXX_W   = 49;
    localparam int SXY_W   = 49;
    localparam int PP_W    = 41;

    // Fit arithmetic widths
    localparam int MA_W    = 64;
    localparam int MB_W    = 32;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int DIV_W   = 112;
    localparam int DSR_W   = 72;

    localparam int MAX_SEGMENTS_DEF = 256;

    localparam logic [CUM_W-1:0] CUM_MAX   = '1;
    localparam logic [A_W-1:0]   A_MIN     = A_W'(4295);
    localparam logic [A_W-1:0]   A_MAX     = '1;
    localparam logic [B_W-1:0]   B_POS_MAX = {1'b0, {(B_W-1){1'b1}}};
    localparam logic [B_W-1:0]   B_NEG_MIN = {1'b1, {(B_W-1){1'b0}}};

    // Register indexes
    localparam logic CFG_P_MIN = 1'b0;
    localparam logic CFG_P_MAX = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POINT,
        ST_PROD,
        ST_ADD,
        ST_CHECK,
        ST_PAD,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_FIX,
        ST_DIVA_GO,
        ST_DIVA_WAIT,
        ST_DIVB_GO,
        ST_DIVB_WAIT,
        ST_OUT
    } state_t;

    // Fit products, in issue order
    typedef enum logic [2:0] {
        OP_NSXY,
        OP_SXSY,
        OP_NSXX,
        OP_SXSX,
        OP_SYDEN,
        OP_NUMSX,
        OP_NDEN
    } mul_op_t;

    typedef struct packed {
        logic    load_item;
        logic    point;
        logic    prod;
        logic    add;
        logic    pad;
        logic    fix;
        logic    a_default;
        logic    mul_start;
        logic    mul_capture;
        mul_op_t mul_op;
        logic    div_start;
        logic    div_sel_b;
        logic    diva_capture;
        logic    divb_capture;
        logic    out_load;
    } bllf_cmd_t;

    typedef struct packed {
        logic room;
        logic last;
        logic count_one;
        logic num_pos;
        logic mul_done;
        logic div_done;
    } bllf_sts_t;

endpackage

### hw/rtl/bid_ladder_line_fit.sv
// Top level of the bid ladder least-squares line fit.
// Depends on bllf_pkg, bllf_ctrl and bllf_dp.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------
//   input    | s_valid / s_ready  | s_quantity, s_price, s_last_segment
//   result   | m_valid / m_ready  | m_coef_a, m_coef_b, m_overflow
//   config   | cfg_wr_en          | cfg_index, cfg_wdata
//
// Each segment word passes through accept, point, products and sums; a dropped
// word past the segment limit skips the products and sums. The last word of a
// ladder also starts the fit: seven shift-add products and two restoring
// divisions (the slope division is skipped for a flat or falling fit).
// A single-segment ladder gets an extra point at p_min with the first price.
// A new word is taken while a finished result waits in its output register.
// aresetn is synchronous, active low; it clears the sums and the sequencer.
module bid_ladder_line_fit #(
    parameter int MAX_SEGMENTS = bllf_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic [bllf_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bllf_pkg::QTY_W-1:0]          s_quantity,
    input  logic signed [bllf_pkg::PRICE_W-1:0] s_price,
    input  logic                                s_last_segment,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bllf_pkg::A_W-1:0]            m_coef_a,
    output logic signed [bllf_pkg::B_W-1:0]     m_coef_b,
    output logic                                m_overflow
);
    import bllf_pkg::*;

    bllf_cmd_t cmd;
    bllf_sts_t sts;

    bllf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bllf_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_quantity     (s_quantity),
        .s_price        (s_price),
        .s_last_segment (s_last_segment),
        .cmd            (cmd),
        .sts            (sts),
        .m_coef_a       (m_coef_a),
        .m_coef_b       (m_coef_b),
        .m_overflow     (m_overflow)
    );

endmodule

### hw/rtl/bllf_mul.sv
// Shift-add signed multiplier, one multiplier bit per cycle.
// Depends on bllf_pkg.
module bllf_mul (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [bllf_pkg::MA_W-1:0]  op_a,
    input  logic signed [bllf_pkg::MB_W-1:0]  op_b,
    output logic                              done,
    output logic signed [bllf_pkg::PROD_W-1:0] prod
);
    import bllf_pkg::*;

    localparam int CNT_W = $clog2(MB_W + 2);

    logic [CNT_W-1:0]  cnt_reg;
    logic [PROD_W-1:0] am_reg;
    logic [MB_W-1:0]   bm_reg;
    logic [PROD_W-1:0] acc_reg;
    logic              neg_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              done_reg;
    logic [MA_W-1:0]   a_mag;
    logic [MB_W-1:0]   b_mag;

    // Take operand magnitudes; sign is applied at the end
    assign a_mag = op_a[MA_W-1] ? MA_W'(-op_a) : MA_W'(op_a);
    assign b_mag = op_b[MB_W-1] ? MB_W'(-op_b) : MB_W'(op_b);

    // Step through multiplier bits, then apply the sign
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                am_reg  <= PROD_W'(a_mag);
                bm_reg  <= b_mag;
                acc_reg <= '0;
                neg_reg <= op_a[MA_W-1] ^ op_b[MB_W-1];
                cnt_reg <= CNT_W'(MB_W + 1);
            end else if (cnt_reg > CNT_W'(1)) begin
                if (bm_reg[0]) begin
                    acc_reg <= acc_reg + am_reg;
                end
                am_reg  <= am_reg << 1;
                bm_reg  <= bm_reg >> 1;
                cnt_reg <= cnt_reg - CNT_W'(1);
            end else if (cnt_reg == CNT_W'(1)) begin
                prod_reg <= neg_reg ? -acc_reg : acc_reg;
                done_reg <= 1'b1;
                cnt_reg  <= '0;
            end
        end
    end

    assign done = done_reg;
    assign prod = $signed(prod_reg);

endmodule

### hw/rtl/bllf_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bllf_pkg.
module bllf_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [bllf_pkg::DIV_W-1:0]  dividend,
    input  logic [bllf_pkg::DSR_W-1:0]  divisor,
    output logic                        done,
    output logic [bllf_pkg::DIV_W-1:0]  quot
);
    import bllf_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] q_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic             done_reg;
    logic [DSR_W:0]   rem_sh;
    logic             fits;

    // Shift in the next dividend bit and try the subtract
    assign rem_sh = {rem_reg, q_reg[DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                q_reg   <= dividend;
                rem_reg <= '0;
                dsr_reg <= divisor;
                cnt_reg <= CNT_W'(DIV_W);
            end else if (cnt_reg != '0) begin
                rem_reg  <= fits ? DSR_W'(rem_sh - {1'b0, dsr_reg}) : DSR_W'(rem_sh);
                q_reg    <= {q_reg[DIV_W-2:0], fits};
                cnt_reg  <= cnt_reg - CNT_W'(1);
                done_reg <= (cnt_reg == CNT_W'(1));
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

### hw/rtl/bllf_ctrl.sv
// Sequencer for the ladder fit: item intake, fit product order, output slot.
// Depends on bllf_pkg.
module bllf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  bllf_pkg::bllf_sts_t  sts,
    output bllf_pkg::bllf_cmd_t  cmd
);
    import bllf_pkg::*;

    state_t  state_reg, state_next;
    mul_op_t op_reg, op_next;
    logic    m_valid_reg;
    logic    slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_valid) state_next = ST_POINT;
            ST_POINT: begin
                if (sts.room)      state_next = ST_PROD;
                else if (sts.last) state_next = ST_CHECK;
                else               state_next = ST_IDLE;
            end
            ST_PROD:      state_next = ST_ADD;
            ST_ADD:       state_next = sts.last ? ST_CHECK : ST_IDLE;
            ST_CHECK:     state_next = sts.count_one ? ST_PAD : ST_MUL_GO;
            ST_PAD:       state_next = ST_PROD;
            ST_MUL_GO:    state_next = ST_MUL_WAIT;
            ST_MUL_WAIT: begin
                if (sts.mul_done) begin
                    if (op_reg == OP_SXSX)     state_next = ST_FIX;
                    else if (op_reg == OP_NDEN) state_next = ST_DIVB_GO;
                    else                       state_next = ST_MUL_GO;
                end
            end
            ST_FIX:       state_next = sts.num_pos ? ST_DIVA_GO : ST_MUL_GO;
            ST_DIVA_GO:   state_next = ST_DIVA_WAIT;
            ST_DIVA_WAIT: if (sts.div_done) state_next = ST_MUL_GO;
            ST_DIVB_GO:   state_next = ST_DIVB_WAIT;
            ST_DIVB_WAIT: if (sts.div_done) state_next = ST_OUT;
            ST_OUT:       if (slot_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Advance the product index
    always_comb begin
        op_next = op_reg;
        if (state_reg == ST_CHECK) begin
            op_next = OP_NSXY;
        end else if (state_reg == ST_MUL_WAIT && sts.mul_done) begin
            unique case (op_reg)
                OP_NSXY:  op_next = OP_SXSY;
                OP_SXSY:  op_next = OP_NSXX;
                OP_NSXX:  op_next = OP_SXSX;
                OP_SXSX:  op_next = OP_SYDEN;
                OP_SYDEN: op_next = OP_NUMSX;
                OP_NUMSX: op_next = OP_NDEN;
                OP_NDEN:  op_next = OP_NDEN;
                default:  op_next = OP_NSXY;
            endcase
        end
    end

    // Commands
    always_comb begin
        cmd        = '0;
        cmd.mul_op = op_reg;
        unique case (state_reg)
            ST_IDLE:      cmd.load_item    = s_valid;
            ST_POINT:     cmd.point        = 1'b1;
            ST_PROD:      cmd.prod         = 1'b1;
            ST_ADD:       cmd.add          = 1'b1;
            ST_PAD:       cmd.pad          = 1'b1;
            ST_MUL_GO:    cmd.mul_start    = 1'b1;
            ST_MUL_WAIT:  cmd.mul_capture  = sts.mul_done;
            ST_FIX: begin
                cmd.fix       = 1'b1;
                cmd.a_default = !sts.num_pos;
            end
            ST_DIVA_GO:   cmd.div_start    = 1'b1;
            ST_DIVA_WAIT: cmd.diva_capture = sts.div_done;
            ST_DIVB_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel_b = 1'b1;
            end
            ST_DIVB_WAIT: cmd.divb_capture = sts.div_done;
            ST_OUT:       cmd.out_load     = slot_free;
            default:      cmd              = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_NSXY;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            // Hold the result word until taken
            if (cmd.out_load)  m_valid_reg <= 1'b1;
            else if (m_ready)  m_valid_reg <= 1'b0;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_mul_not_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_start |=> !sts.mul_done)
        else $error("multiplier reported done right after start");
    a_out_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("result load did not raise m_valid");
    a_idle_no_units: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !cmd.mul_start && !cmd.div_start && !cmd.out_load)
        else $error("arithmetic unit started while taking words");
`endif

endmodule

### hw/rtl/bllf_dp.sv
// Datapath: config registers, ladder sums, fit operands and result registers.
// Depends on bllf_pkg, bllf_mul and bllf_div.
module bllf_dp #(
    parameter int MAX_SEGMENTS = bllf_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_index,
    input  logic [bllf_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [bllf_pkg::QTY_W-1:0]         s_quantity,
    input  logic signed [bllf_pkg::PRICE_W-1:0] s_price,
    input  logic                               s_last_segment,
    input  bllf_pkg::bllf_cmd_t                cmd,
    output bllf_pkg::bllf_sts_t                sts,
    output logic [bllf_pkg::A_W-1:0]           m_coef_a,
    output logic signed [bllf_pkg::B_W-1:0]    m_coef_b,
    output logic                               m_overflow
);
    import bllf_pkg::*;

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 2);

    logic [CFG_W-1:0]          p_min_reg, p_max_reg;
    logic [QTY_W-1:0]          qty_reg;
    logic signed [PRICE_W-1:0] price_reg;
    logic                      last_reg;

    logic [CUM_W-1:0]          cum_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [SX_W-1:0]           sx_reg;
    logic signed [SY_W-1:0]    sy_reg;
    logic [SXX_W-1:0]          sxx_reg;
    logic signed [SXY_W-1:0]   sxy_reg;
    logic signed [PRICE_W-1:0] first_reg;
    logic                      ovf_reg;

    logic [CFG_W-1:0]          x_reg;
    logic signed [PRICE_W-1:0] y_reg;
    logic [2*CFG_W-1:0]        xx_reg;
    logic signed [PP_W-1:0]    xy_reg;

    logic signed [PROD_W-1:0]  t_reg;
    logic signed [MA_W-1:0]    num_reg, den_reg;
    logic signed [PROD_W-1:0]  bnum_reg;
    logic [DSR_W-1:0]          dsr_reg;
    logic [A_W-1:0]            a_reg;
    logic [B_W-1:0]            b_reg;

    logic [A_W-1:0]            out_a_reg;
    logic [B_W-1:0]            out_b_reg;
    logic                      out_ovf_reg;

    logic [CUM_W:0]            cum_sum;
    logic [CUM_W-1:0]          cum_sat;
    logic [CUM_W:0]            x_sum;
    logic [CFG_W-1:0]          x_new;
    logic                      room;
    logic                      den_pos;

    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic                      mul_done;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [PROD_W-1:0]  t_minus_p;

    logic [PROD_W-1:0]         bnum_mag;
    logic [DIV_W-1:0]          div_dividend;
    logic [DSR_W-1:0]          div_divisor;
    logic                      div_done;
    logic [DIV_W-1:0]          div_q;
    logic                      b_neg_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_min_reg <= '0;
            p_max_reg <= '1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_P_MIN: p_min_reg <= cfg_wdata;
                CFG_P_MAX: p_max_reg <= cfg_wdata;
                default:   p_min_reg <= p_min_reg;
            endcase
        end
    end

    // Next point: saturate the running quantity, clamp x to p_max
    assign cum_sum = {1'b0, cum_reg} + (CUM_W+1)'(qty_reg);
    assign cum_sat = cum_sum[CUM_W] ? CUM_MAX : cum_sum[CUM_W-1:0];
    assign x_sum   = {1'b0, cum_sat} + (CUM_W+1)'(p_min_reg);
    assign x_new   = (x_sum > (CUM_W+1)'(p_max_reg)) ? p_max_reg : x_sum[CFG_W-1:0];
    assign room    = count_reg < CNT_W'(MAX_SEGMENTS);

    // Latch the input word
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            qty_reg   <= s_quantity;
            price_reg <= s_price;
            last_reg  <= s_last_segment;
        end
    end

    // Point and product registers
    always_ff @(posedge aclk) begin
        if (cmd.point) begin
            x_reg <= x_new;
            y_reg <= price_reg;
        end else if (cmd.pad) begin
            x_reg <= p_min_reg;
            y_reg <= first_reg;
        end
        if (cmd.prod) begin
            xx_reg <= x_reg * x_reg;
            xy_reg <= PP_W'($signed({1'b0, x_reg}) * y_reg);
        end
    end

    // Ladder sums; clear after each fit
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.out_load) begin
            cum_reg   <= '0;
            count_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            sxy_reg   <= '0;
            first_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            if (cmd.point) begin
                if (room) begin
                    cum_reg <= cum_sat;
                    if (count_reg == '0) first_reg <= price_reg;
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.add) begin
                count_reg <= count_reg + CNT_W'(1);
                sx_reg    <= sx_reg + SX_W'(x_reg);
                sy_reg    <= sy_reg + {{(SY_W-PRICE_W){y_reg[PRICE_W-1]}}, y_reg};
                sxx_reg   <= sxx_reg + SXX_W'(xx_reg);
                sxy_reg   <= sxy_reg + {{(SXY_W-PP_W){xy_reg[PP_W-1]}}, xy_reg};
            end
        end
    end

    // Fit product operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            OP_NSXY: begin
                mul_a = {{(MA_W-SXY_W){sxy_reg[SXY_W-1]}}, sxy_reg};
                mul_b = MB_W'(count_reg);
            end
            OP_SXSY: begin
                mul_a = {{(MA_W-SY_W){sy_reg[SY_W-1]}}, sy_reg};
                mul_b = MB_W'(sx_reg);
            end
            OP_NSXX: begin
                mul_a = MA_W'(sxx_reg);
                mul_b = MB_W'(count_reg);
            end
            OP_SXSX: begin
                mul_a = MA_W'(sx_reg);
                mul_b = MB_W'(sx_reg);
            end
            OP_SYDEN: begin
                mul_a = den_reg;
                mul_b = {{(MB_W-SY_W){sy_reg[SY_W-1]}}, sy_reg};
            end
            OP_NUMSX: begin
                mul_a = num_reg;
                mul_b = MB_W'(sx_reg);
            end
            OP_NDEN: begin
                mul_a = den_reg;
                mul_b = MB_W'(count_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    bllf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .prod    (mul_p)
    );

    assign t_minus_p = t_reg - mul_p;
    assign den_pos   = !den_reg[MA_W-1] && (den_reg != '0);

    // Capture products; force a flat fit when den is not positive
    always_ff @(posedge aclk) begin
        if (cmd.mul_capture) begin
            case (cmd.mul_op)
                OP_NSXY, OP_NSXX, OP_SYDEN: t_reg <= mul_p;
                OP_SXSY:  num_reg  <= MA_W'(t_minus_p);
                OP_SXSX:  den_reg  <= MA_W'(t_minus_p);
                OP_NUMSX: bnum_reg <= t_minus_p;
                OP_NDEN:  dsr_reg  <= DSR_W'(mul_p);
                default:  t_reg    <= t_reg;
            endcase
        end else if (cmd.fix && !den_pos) begin
            num_reg <= '0;
            den_reg <= MA_W'(1);
        end
    end

    // Divider operands: slope or intercept
    assign bnum_mag     = bnum_reg[PROD_W-1] ? PROD_W'(-bnum_reg) : PROD_W'(bnum_reg);
    assign div_dividend = cmd.div_sel_b ? DIV_W'({bnum_mag, 16'b0})
                                        : DIV_W'({num_reg, 31'b0});
    assign div_divisor  = cmd.div_sel_b ? dsr_reg : DSR_W'(den_reg);

    bllf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_q)
    );

    // Saturate the coefficients; a also has a floor of A_MIN
    always_ff @(posedge aclk) begin
        if (cmd.div_start && cmd.div_sel_b) begin
            b_neg_reg <= bnum_reg[PROD_W-1];
        end
        if (cmd.a_default) begin
            a_reg <= A_MIN;
        end else if (cmd.diva_capture) begin
            if (div_q[DIV_W-1:A_W] != '0)  a_reg <= A_MAX;
            else if (div_q[A_W-1:0] < A_MIN) a_reg <= A_MIN;
            else                             a_reg <= div_q[A_W-1:0];
        end
        if (cmd.divb_capture) begin
            if (b_neg_reg) begin
                if (div_q[DIV_W-1:B_W] != '0 || div_q[B_W-1:0] > B_NEG_MIN)
                    b_reg <= B_NEG_MIN;
                else
                    b_reg <= -div_q[B_W-1:0];
            end else begin
                if (div_q[DIV_W-1:B_W-1] != '0) b_reg <= B_POS_MAX;
                else                            b_reg <= div_q[B_W-1:0];
            end
        end
    end

    // Output word
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_a_reg   <= a_reg;
            out_b_reg   <= b_reg;
            out_ovf_reg <= ovf_reg;
        end
    end

    assign sts.room      = room;
    assign sts.last      = last_reg;
    assign sts.count_one = (count_reg == CNT_W'(1));
    assign sts.num_pos   = den_pos && !num_reg[MA_W-1] && (num_reg != '0);
    assign sts.mul_done  = mul_done;
    assign sts.div_done  = div_done;

    assign m_coef_a   = out_a_reg;
    assign m_coef_b   = $signed(out_b_reg);
    assign m_overflow = out_ovf_reg;

endmodule

### tb/sv/bllf_fit_checker.sv
// Scoreboard for the bid ladder line fit: watches the config port and both channels,
// predicts the fitted coefficients for every ladder and compares them with the results.
// Depends on bllf_pkg.
module bllf_fit_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic [bllf_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [bllf_pkg::QTY_W-1:0]          s_quantity,
    input  logic signed [bllf_pkg::PRICE_W-1:0] s_price,
    input  logic                                s_last_segment,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [bllf_pkg::A_W-1:0]            m_coef_a,
    input  logic signed [bllf_pkg::B_W-1:0]     m_coef_b,
    input  logic                                m_overflow,
    output int                                  fail_count,
    output int                                  fits_pending,
    output int                                  fits_seen
);
    import bllf_pkg::*;

    typedef struct {
        logic [A_W-1:0] coef_a;
        logic [B_W-1:0] coef_b;
        logic           overflow;
    } fit_word_t;

    localparam int LADDER_CAP = MAX_SEGMENTS_DEF;

    fit_word_t      fit_queue[$];
    logic [CFG_W-1:0] start_power = '0;
    logic [CFG_W-1:0] clamp_power = '1;
    longint cum_power, n_points, sx, sy, sxx, sxy, first_px;
    logic   dropped;

    initial begin
        fail_count = 0;
        fits_pending = 0;
        fits_seen = 0;
    end

    function automatic void clear_ladder();
        cum_power = 0;
        n_points = 0;
        sx = 0;
        sy = 0;
        sxx = 0;
        sxy = 0;
        first_px = 0;
        dropped = 1'b0;
    endfunction

    function automatic void add_point(longint x, longint y);
        n_points++;
        sx += x;
        sy += y;
        sxx += x * x;
        sxy += x * y;
    endfunction

    // Exact least-squares fit of the current ladder
    function automatic fit_word_t solve_ladder();
        logic signed [159:0] n, num, den, bnum, mag, quo, aq;
        logic neg;
        fit_word_t w;
        n = n_points;
        num = n * sxy - 160'(signed'(sx)) * sy;
        den = n * sxx - 160'(signed'(sx)) * sx;
        w.coef_a = A_MIN;
        if (den <= 0) begin
            num = 0;
            den = 1;
        end else if (num > 0) begin
            if ((num >>> 16) >= den) begin
                w.coef_a = A_MAX;
            end else begin
                aq = (num <<< 31) / den;
                w.coef_a = (aq < 4295) ? A_MIN : aq[A_W-1:0];
            end
        end
        bnum = 160'(signed'(sy)) * den - num * sx;
        neg = bnum < 0;
        mag = neg ? -bnum : bnum;
        quo = (mag <<< 16) / (n * den);
        if (neg) begin
            w.coef_b = (quo > 160'sh800000000000) ? B_NEG_MIN : B_W'(-quo);
        end else begin
            w.coef_b = (quo > 160'sh7FFFFFFFFFFF) ? B_POS_MAX : quo[B_W-1:0];
        end
        w.overflow = dropped;
        return w;
    endfunction

    initial clear_ladder();

    always @(posedge aclk) begin
        longint x;
        fit_word_t exp_w;
        if (!aresetn) begin
            start_power = '0;
            clamp_power = '1;
            clear_ladder();
            fit_queue.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_P_MIN) start_power = cfg_wdata;
                else clamp_power = cfg_wdata;
            end
            // Fold an accepted segment into the ladder sums
            if (s_valid && s_ready) begin
                if (n_points < LADDER_CAP) begin
                    cum_power += s_quantity;
                    if (cum_power > CUM_MAX) cum_power = CUM_MAX;
                    x = start_power + cum_power;
                    if (x > clamp_power) x = clamp_power;
                    if (n_points == 0) first_px = s_price;
                    add_point(x, s_price);
                end else begin
                    dropped = 1'b1;
                end
                if (s_last_segment) begin
                    if (n_points == 1) add_point(start_power, first_px);
                    fit_queue.insert(fit_queue.size(), solve_ladder());
                    clear_ladder();
                end
            end
            // Compare a delivered result with the oldest expected fit
            if (m_valid && m_ready) begin
                fits_seen++;
                if (fit_queue.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result a=%0d b=%0d ovf=%0d",
                             $time, m_coef_a, m_coef_b, m_overflow);
                end else begin
                    exp_w = fit_queue.pop_front();
                    if (m_coef_a !== exp_w.coef_a) begin
                        fail_count++;
                        $display("%0t: coef_a expected %0d got %0d",
                                 $time, exp_w.coef_a, m_coef_a);
                    end
                    if (m_coef_b !== exp_w.coef_b) begin
                        fail_count++;
                        $display("%0t: coef_b expected %0d got %0d", $time,
                                 $signed(exp_w.coef_b), m_coef_b);
                    end
                    if (m_overflow !== exp_w.overflow) begin
                        fail_count++;
                        $display("%0t: overflow expected %0d got %0d",
                                 $time, exp_w.overflow, m_overflow);
                    end
                end
            end
            fits_pending = fit_queue.size();
        end
    end
endmodule

### tb/sv/tb_bid_ladder_line_fit.sv
// Top of the bid ladder line fit testbench: clock, reset, config writes and ladder stimulus.
// Depends on bllf_pkg, bid_ladder_line_fit and bllf_fit_checker.
module tb_bid_ladder_line_fit;
    import bllf_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int FIT_SETTLE = 700;
    localparam int PHASE_WORDS = 325;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_index = CFG_P_MIN;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [QTY_W-1:0] s_quantity = '0;
    logic signed [PRICE_W-1:0] s_price = '0;
    logic s_last_segment = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [A_W-1:0] m_coef_a;
    logic signed [B_W-1:0] m_coef_b;
    logic m_overflow;

    int fail_count, fits_pending, fits_seen;
    int words_sent = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int quiet_cycles = 0;

    bid_ladder_line_fit uut (.*);

    bllf_fit_checker checker_i (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no traffic for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold a segment word until it is taken, then maybe idle
    task automatic send_segment(logic [QTY_W-1:0] qty, logic [PRICE_W-1:0] px,
                                logic last);
        s_valid <= 1'b1;
        s_quantity <= qty;
        s_price <= px;
        s_last_segment <= last;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic send_ladder(int len, bit wide_qty);
        int base, step, noise;
        base = $urandom_range(0, 200000) - 100000;
        step = $urandom_range(0, 2000) - 1000;
        noise = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 5000);
        for (int i = 0; i < len; i++) begin
            logic [QTY_W-1:0] q;
            logic [PRICE_W-1:0] p;
            q = wide_qty ? QTY_W'($urandom) : QTY_W'($urandom_range(0, 6000));
            if ($urandom_range(0, 4) == 0) p = PRICE_W'($urandom);
            else p = PRICE_W'(base + i * step + (noise ? $urandom_range(0, noise) : 0));
            send_segment(q, p, i == len - 1);
        end
    endtask

    // Let every fit come back before touching the registers
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (fits_pending != 0) @(posedge aclk);
        repeat (FIT_SETTLE) @(posedge aclk);
    endtask

    initial begin
        logic [CFG_W-1:0] pmin_set[4];
        logic [CFG_W-1:0] pmax_set[4];
        int stop_at, len;
        pmin_set = '{20'd0, 20'd1000, 20'hFFFFF, 20'd500};
        pmax_set = '{20'hFFFFF, 20'd60000, 20'd0, 20'd500};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 88 : 0;
            rx_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 28 : 0;
            write_reg(CFG_P_MIN, pmin_set[ph]);
            write_reg(CFG_P_MAX, pmax_set[ph]);
            if (ph == 0) begin
                // Single segments at the price extremes
                send_segment(20'hFFFFF, 20'h7FFFF, 1'b1);
                send_segment(20'h00000, 20'h80000, 1'b1);
                // Flat x: no quantity, so the slope falls back to A_MIN
                send_segment(20'd0, 20'd100, 1'b0);
                send_segment(20'd0, 20'd300, 1'b0);
                send_segment(20'd0, 20'd200, 1'b1);
                // Rising and falling ladders
                for (int i = 0; i < 4; i++) send_segment(20'd500, 20'(1000 * i), i == 3);
                for (int i = 0; i < 4; i++) send_segment(20'd700, 20'(-3000 * i), i == 3);
            end
            stop_at = words_sent + PHASE_WORDS;
            while (words_sent < stop_at) begin
                if ($urandom_range(0, 29) == 0) begin
                    len = $urandom_range(0, 1) ? 256 : $urandom_range(257, 262);
                    send_ladder(len, $urandom_range(0, 1));
                end else begin
                    len = $urandom_range(1, 16);
                    send_ladder(len, $urandom_range(0, 7) == 0);
                end
            end
            wait_drained();
        end

        $display("Sent %0d segment words over 4 register settings; %0d fits checked.",
                 words_sent, fits_seen);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
